### design/nfs_pkg.sv
// Package for the nearest fraction search unit.
// Holds the sequencer state type and fixed search constants.
// No dependencies.
`timescale 1ns / 1ps
package nfs_pkg;
    localparam int unsigned TOL_W     = 21;
    localparam int unsigned NUM_W     = 41;
    localparam int unsigned DEN_W     = 17;
    localparam int unsigned VAL_W     = 64;
    localparam int unsigned BND_W     = 18;
    localparam logic [BND_W-1:0] NUM_LIMIT_ODD  = 18'h08000;
    localparam logic [BND_W-1:0] NUM_LIMIT_EVEN = 18'h10000;
    localparam logic [BND_W-1:0] COUNT_SAT      = 18'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_A,
        ST_ERR_B,
        ST_TEST,
        ST_DIV,
        ST_CAND_A,
        ST_CAND_B,
        ST_CHECK,
        ST_RES_A,
        ST_RES_B,
        ST_OUT
    } t_state;
endpackage

### design/nfs_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Quotient saturates at the package count limit; zero divisor gives the limit.
// Depends on nfs_pkg.
`timescale 1ns / 1ps
module nfs_divider #(
    parameter int unsigned W = 66
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [W-1:0]             i_dividend,
    input  logic [W-1:0]             i_divisor,
    output logic                     o_done,
    output logic [nfs_pkg::BND_W-1:0] o_quot
);
    import nfs_pkg::*;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0] r_rem, n_rem_v;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_dvs;
    logic [W-1:0] r_dvd;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem, r_dvd[W-1]};
    assign n_rem_v = (w_trial >= {1'b0, r_dvs}) ? W'(w_trial - {1'b0, r_dvs}) : w_trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem_v;
            r_quo <= {r_quo[W-2:0], (w_trial >= {1'b0, r_dvs})};
            r_dvd <= {r_dvd[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_dvs == '0 || r_quo > W'(COUNT_SAT)) ? COUNT_SAT : r_quo[BND_W-1:0];
endmodule

### design/nearest_fraction_search_unit.sv
// Nearest fraction search unit: top level with sequencer and datapath.
// Depends on nfs_pkg and nfs_divider.
`timescale 1ns / 1ps
// Takes a signed fixed-point value with FRAC_BITS fraction bits and returns the
// closest fraction whose denominator stays within DEN_LIMIT, by a mediant search
// of up to MAX_STEPS steps. Each step runs one division on the shared serial
// divider between the sequencer states ERR_A, ERR_B and TEST and the states
// CAND_A, CAND_B and CHECK; a result waits in OUT through any output stall, and
// the input is not ready until the result has been transferred. tolerance is
// written on the config channel while the unit is idle.
module nearest_fraction_search_unit #(
    parameter int unsigned FRAC_BITS = 40,
    parameter int unsigned MAX_STEPS = 100,
    parameter int unsigned DEN_LIMIT = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,   // value[63:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // numerator[40:0], denominator[57:41]
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nfs_pkg::TOL_W-1:0]     i_cfg_data
);
    import nfs_pkg::*;
    localparam int unsigned EW = FRAC_BITS + 26;
    localparam int unsigned SW = $clog2(MAX_STEPS + 1);

    t_state r_state, n_state;
    logic [TOL_W-1:0]   r_tol;
    logic               r_neg;
    logic [VAL_W-1:0]   r_ipart;
    logic [FRAC_BITS-1:0] r_x;
    logic [BND_W-1:0]   r_ln, r_ld, r_hn, r_hd;
    logic [EW-1:0]      r_el, r_eh;
    logic [SW-1:0]      r_step;
    logic [BND_W-1:0]   r_k;
    logic [EW-1:0]      r_cn, r_cd;
    logic [VAL_W-1:0]   r_res;
    logic [NUM_W-1:0]   r_onum;
    logic [DEN_W-1:0]   r_oden;

    logic               w_odd, w_div_start, w_div_done;
    logic [EW-1:0]      w_one, w_tl, w_th, w_dvd, w_dvs;
    logic [BND_W-1:0]   w_q;
    logic [VAL_W-1:0]   w_mag;
    logic               w_stop_h, w_stop_l, w_over, w_last;

    assign w_odd  = r_step[0];
    assign w_one  = EW'(1) << FRAC_BITS;
    assign w_tl   = EW'(r_tol) * EW'(r_ld);
    assign w_th   = EW'(r_tol) * EW'(r_hd);
    assign w_stop_h = r_eh < w_th;
    assign w_stop_l = r_el < w_tl;
    assign w_over = (r_cn > EW'(w_odd ? NUM_LIMIT_ODD : NUM_LIMIT_EVEN))
                 || (r_cd > EW'(DEN_LIMIT));
    assign w_last = (r_step == SW'(MAX_STEPS - 1));
    assign w_dvd  = w_odd ? r_eh : r_el;
    assign w_dvs  = w_odd ? r_el : r_eh;
    assign w_mag  = s_axis_tdata[63] ? (64'd0 - s_axis_tdata) : s_axis_tdata;

    nfs_divider #(.W(EW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_ERR_A;
            ST_ERR_A:  n_state = ST_ERR_B;
            ST_ERR_B:  n_state = ST_TEST;
            ST_TEST: begin
                if (w_stop_h || w_stop_l) n_state = ST_RES_A;
                else n_state = ST_DIV;
            end
            ST_DIV:    if (w_div_done) n_state = ST_CAND_A;
            ST_CAND_A: n_state = ST_CAND_B;
            ST_CAND_B: n_state = ST_CHECK;
            ST_CHECK: begin
                if (w_over || w_last) n_state = ST_RES_A;
                else n_state = ST_ERR_A;
            end
            ST_RES_A:  n_state = ST_RES_B;
            ST_RES_B:  n_state = ST_OUT;
            ST_OUT:    if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_OUT);
        o_cfg_ready   = (r_state == ST_IDLE);
        w_div_start   = (r_state == ST_TEST) && !w_stop_h && !w_stop_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tol   <= TOL_W'(11);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_tol <= i_cfg_data;
        end
    end

    // datapath: one product per register stage
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_neg   <= s_axis_tdata[63];
                r_ipart <= w_mag >> FRAC_BITS;
                r_x     <= w_mag[FRAC_BITS-1:0];
                r_ln <= '0; r_ld <= BND_W'(1);
                r_hn <= BND_W'(1); r_hd <= BND_W'(1);
                r_step <= '0;
            end
            ST_ERR_A: begin
                r_el <= EW'(r_ld) * EW'(r_x);
                r_eh <= EW'(r_hd) * EW'(r_x);
            end
            ST_ERR_B: begin
                r_el <= r_el - EW'(r_ln) * w_one;
                r_eh <= EW'(r_hn) * w_one - r_eh;
            end
            ST_TEST: begin
                if (!w_stop_h && w_stop_l) begin
                    r_hn <= r_ln;
                    r_hd <= r_ld;
                end
            end
            ST_DIV:  if (w_div_done) r_k <= w_q;
            ST_CAND_A: begin
                if (w_odd) begin
                    r_cn <= (EW'(r_k) + 1'b1) * EW'(r_ln);
                    r_cd <= (EW'(r_k) + 1'b1) * EW'(r_ld);
                end else begin
                    r_cn <= (EW'(r_k) + 1'b1) * EW'(r_hn);
                    r_cd <= (EW'(r_k) + 1'b1) * EW'(r_hd);
                end
            end
            ST_CAND_B: begin
                if (w_odd) begin
                    r_cn <= r_cn + EW'(r_hn);
                    r_cd <= r_cd + EW'(r_hd);
                end else begin
                    r_cn <= r_cn + EW'(r_ln);
                    r_cd <= r_cd + EW'(r_ld);
                end
            end
            ST_CHECK: begin
                if (!w_over) begin
                    r_step <= r_step + 1'b1;
                    if (w_odd) begin
                        r_hn <= BND_W'(r_cn) - r_ln;
                        r_hd <= BND_W'(r_cd) - r_ld;
                        r_ln <= BND_W'(r_cn);
                        r_ld <= BND_W'(r_cd);
                    end else begin
                        r_ln <= BND_W'(r_cn) - r_hn;
                        r_ld <= BND_W'(r_cd) - r_hd;
                        r_hn <= BND_W'(r_cn);
                        r_hd <= BND_W'(r_cd);
                    end
                end
            end
            ST_RES_A: r_res <= r_ipart * VAL_W'(r_hd);
            ST_RES_B: begin
                r_onum <= r_neg ? NUM_W'(64'd0 - (r_res + VAL_W'(r_hn)))
                                : NUM_W'(r_res + VAL_W'(r_hn));
                r_oden <= DEN_W'(r_hd);
            end
            default: ;
        endcase
    end

    assign m_axis_tdata = {6'd0, r_oden, r_onum};
endmodule
